### rtl/bba_pkg.sv
// Shared types and constants for the buddy block allocator.
package bba_pkg;

  localparam int MAX_ORDER   = 8;
  localparam int UNIT_W      = MAX_ORDER;
  localparam int POOL_UNITS  = 1 << MAX_ORDER;
  localparam int UNIT_SHIFT  = 8;
  localparam int POOL_BYTES  = POOL_UNITS << UNIT_SHIFT;
  localparam int ORD_W       = 4;
  localparam int QDEPTH      = 16;
  localparam int QIDX_W      = 4;
  localparam int QCNT_W      = 5;
  localparam int BIT_W       = 4;
  localparam int WORD_BITS   = 1 << BIT_W;
  localparam int WIDX_W      = UNIT_W - BIT_W;
  localparam int FADDR_W     = ORD_W + WIDX_W;
  localparam int FDEPTH      = (MAX_ORDER + 1) << WIDX_W;
  localparam int SIZE_W      = 17;
  localparam int BOFF_W      = 18;
  localparam int FRAME_W     = 32;
  localparam int TOTAL_W     = UNIT_W + 1;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NOSPACE = 2'd1,
    ST_QFULL   = 2'd2,
    ST_INVALID = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    REQ_ALLOC   = 2'd0,
    REQ_RELEASE = 2'd1,
    REQ_CLEAN   = 2'd2
  } req_e;

  typedef enum logic [1:0] {
    OP_ALLOC,
    OP_RELEASE,
    OP_CLEAN,
    OP_REJECT
  } op_e;

  typedef struct packed {
    op_e                 op;
    logic [SIZE_W-1:0]   size;
    logic [SIZE_W-1:0]   align;
    logic [UNIT_W-1:0]   offs;
    logic [ORD_W-1:0]    order;
    logic [FRAME_W-1:0]  frame;
  } cmd_t;

  typedef enum logic [3:0] {
    BK_IDLE,
    BK_A_DIV1,
    BK_A_RD,
    BK_A_SCAN,
    BK_A_SPLIT_RD,
    BK_A_SPLIT_WR,
    BK_A_ADDR,
    BK_A_DIV2,
    BK_C_CHK,
    BK_F_RD,
    BK_F_CHK,
    BK_F_SET_RD,
    BK_F_SET_WR
  } bk_state_e;

endpackage

### rtl/buddy_block_allocator_core.sv
// Top level of the buddy block allocator.
// Buddy allocator over 256 units of 256 bytes. Requests enter through a queue
// interface (push/full) and each yields one result (empty/pop). A two-entry
// command queue decouples decode from execution, so requests are taken while
// a result waits. Allocate runs two bit-serial alignment round-ups, scans
// flag-memory words (16 words per order, orders k..8) and then splits;
// release and rejects finish straight from idle; cleanup checks each queue
// entry in turn, merges step by step and sets a final flag per freed entry.
// The flag memory port, one read-modify-write per step, sets the search
// and merge pace. No clearing pass is needed.
module buddy_block_allocator_core import bba_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  logic [1:0]         req_type_i,
  input  logic [SIZE_W-1:0]  size_bytes_i,
  input  logic [SIZE_W-1:0]  alignment_i,
  input  logic [UNIT_W-1:0]  block_offset_units_i,
  input  logic [ORD_W-1:0]   block_order_i,
  input  logic [FRAME_W-1:0] frame_count_i,
  output logic               empty,
  input  logic               pop,
  output logic [1:0]         status_o,
  output logic [UNIT_W-1:0]  unit_offset_o,
  output logic [ORD_W-1:0]   alloc_order_o,
  output logic [BOFF_W-1:0]  aligned_byte_offset_o,
  output logic [QCNT_W-1:0]  freed_count_o
);

  cmd_t fe_cmd, q_cmd;
  logic q_valid, q_pop, res_valid;

  bba_front u_front (
    .req_type_i           (req_type_i),
    .size_bytes_i         (size_bytes_i),
    .alignment_i          (alignment_i),
    .block_offset_units_i (block_offset_units_i),
    .block_order_i        (block_order_i),
    .frame_count_i        (frame_count_i),
    .cmd_o                (fe_cmd)
  );

  bba_cmd_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (fe_cmd),
    .full_o  (full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .cmd_o   (q_cmd)
  );

  bba_back u_back (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .cmd_valid_i           (q_valid),
    .cmd_i                 (q_cmd),
    .cmd_pop_o             (q_pop),
    .res_valid_o           (res_valid),
    .res_pop_i             (pop),
    .status_o              (status_o),
    .unit_offset_o         (unit_offset_o),
    .alloc_order_o         (alloc_order_o),
    .aligned_byte_offset_o (aligned_byte_offset_o),
    .freed_count_o         (freed_count_o)
  );

  assign empty = !res_valid;

endmodule

### rtl/bba_front.sv
// Request decode and validation into back-end commands.
module bba_front import bba_pkg::*; (
  input  logic [1:0]         req_type_i,
  input  logic [SIZE_W-1:0]  size_bytes_i,
  input  logic [SIZE_W-1:0]  alignment_i,
  input  logic [UNIT_W-1:0]  block_offset_units_i,
  input  logic [ORD_W-1:0]   block_order_i,
  input  logic [FRAME_W-1:0] frame_count_i,
  output cmd_t               cmd_o
);

  logic [UNIT_W:0] low_mask;

  // Classify the request
  always_comb begin
    low_mask     = (UNIT_W+1)'((UNIT_W+1)'(1) << block_order_i) - (UNIT_W+1)'(1);
    cmd_o.size   = size_bytes_i;
    cmd_o.align  = alignment_i;
    cmd_o.offs   = block_offset_units_i;
    cmd_o.order  = block_order_i;
    cmd_o.frame  = frame_count_i;
    case (req_type_i)
      REQ_ALLOC: begin
        cmd_o.op = (size_bytes_i == '0) ? OP_REJECT : OP_ALLOC;
      end
      REQ_RELEASE: begin
        if (block_order_i > ORD_W'(MAX_ORDER) ||
            (block_offset_units_i & low_mask[UNIT_W-1:0]) != '0) begin
          cmd_o.op = OP_REJECT;
        end else begin
          cmd_o.op = OP_RELEASE;
        end
      end
      REQ_CLEAN: cmd_o.op = OP_CLEAN;
      default:   cmd_o.op = OP_REJECT;
    endcase
  end

endmodule

### rtl/bba_cmd_fifo.sv
// Two-entry command queue between front and back end.
module bba_cmd_fifo import bba_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t cmd_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output cmd_t cmd_o
);

  cmd_t       mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  logic       do_push, do_pop;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign cmd_o   = mem_q[rp_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // Store pushed commands
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wp_q] <= cmd_i;
    end
  end

  // Advance pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (do_push) wp_q <= ~wp_q;
      if (do_pop)  rp_q <= ~rp_q;
      cnt_q <= cnt_q + 2'(do_push) - 2'(do_pop);
    end
  end

endmodule

### rtl/bba_div.sv
// Bit-serial round-up of a value to a multiple of an alignment.
module bba_div import bba_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [SIZE_W-1:0] val_i,
  input  logic [SIZE_W-1:0] aln_i,
  output logic              done_o,
  output logic [BOFF_W-1:0] res_o
);

  logic              busy_q;
  logic [4:0]        cnt_q;
  logic [SIZE_W-1:0] val_q, sh_q, aln_q, rem_q;
  logic [SIZE_W:0]   trial;

  assign done_o = busy_q && (cnt_q == 5'd0);
  assign trial  = {rem_q, sh_q[SIZE_W-1]};

  // Add the gap to the next multiple
  always_comb begin
    if (aln_q == '0 || rem_q == '0) begin
      res_o = BOFF_W'(val_q);
    end else begin
      res_o = BOFF_W'(val_q) + BOFF_W'(aln_q) - BOFF_W'(rem_q);
    end
  end

  // Shift in one dividend bit per cycle
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      val_q <= val_i;
      sh_q  <= val_i;
      aln_q <= aln_i;
      rem_q <= '0;
    end else if (busy_q && cnt_q != 5'd0) begin
      sh_q <= sh_q << 1;
      if (trial >= {1'b0, aln_q}) begin
        rem_q <= SIZE_W'(trial - {1'b0, aln_q});
      end else begin
        rem_q <= trial[SIZE_W-1:0];
      end
    end
  end

  // Track the iteration count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= 5'd0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= 5'(SIZE_W);
    end else if (busy_q) begin
      if (cnt_q == 5'd0) busy_q <= 1'b0;
      else               cnt_q  <= cnt_q - 5'd1;
    end
  end

endmodule

### rtl/bba_back.sv
// Back end: free-flag memory, release queue and the allocate/cleanup sequencer.
module bba_back import bba_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cmd_valid_i,
  input  cmd_t               cmd_i,
  output logic               cmd_pop_o,
  output logic               res_valid_o,
  input  logic               res_pop_i,
  output logic [1:0]         status_o,
  output logic [UNIT_W-1:0]  unit_offset_o,
  output logic [ORD_W-1:0]   alloc_order_o,
  output logic [BOFF_W-1:0]  aligned_byte_offset_o,
  output logic [QCNT_W-1:0]  freed_count_o
);

  localparam logic [FADDR_W-1:0] ROOT_ADDR = {ORD_W'(MAX_ORDER), WIDX_W'(0)};

  // Free-flag memory, one word per (order, offset row)
  logic [WORD_BITS-1:0] fmem [FDEPTH];
  logic [FDEPTH-1:0]    vld_q;
  logic                 rd_en, wr_en;
  logic [FADDR_W-1:0]   rd_addr, wr_addr, rd_addr_q;
  logic [WORD_BITS-1:0] wr_data, rd_data_q, rdw;

  // Release queue
  logic [UNIT_W-1:0]  qoff_q   [QDEPTH];
  logic [ORD_W-1:0]   qord_q   [QDEPTH];
  logic [FRAME_W-1:0] qstamp_q [QDEPTH];
  logic [QIDX_W-1:0]  head_q, head_d, tail;
  logic [QCNT_W-1:0]  cnt_q, cnt_d;
  logic               q_wr;

  bk_state_e          st_q, st_d;
  cmd_t               cmd_q, cmd_d;
  logic [ORD_W-1:0]   ord_q, ord_d, k_q, k_d;
  logic [WIDX_W-1:0]  wrd_q, wrd_d;
  logic [UNIT_W-1:0]  off_q, off_d;
  logic [TOTAL_W-1:0] total_q, total_d;
  logic [QCNT_W-1:0]  freed_q, freed_d;

  logic               res_v_q, res_v_d;
  status_e            res_st_q, res_st_d;
  logic [UNIT_W-1:0]  res_off_q, res_off_d;
  logic [ORD_W-1:0]   res_ord_q, res_ord_d;
  logic [BOFF_W-1:0]  res_boff_q, res_boff_d;
  logic [QCNT_W-1:0]  res_fr_q, res_fr_d;

  logic               div_start, div_done;
  logic [SIZE_W-1:0]  div_val, div_aln;
  logic [BOFF_W-1:0]  div_res;

  logic [BOFF_W-1:0]  units;
  logic [ORD_W-1:0]   kc;
  logic [BIT_W-1:0]   lsb;
  logic               lsb_hit;
  logic [UNIT_W-1:0]  tgt, bud;
  logic [TOTAL_W:0]   tsum;
  logic [TOTAL_W-1:0] relu;

  bba_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .val_i   (div_val),
    .aln_i   (div_aln),
    .done_o  (div_done),
    .res_o   (div_res)
  );

  assign rdw = vld_q[rd_addr_q] ? rd_data_q
             : ((rd_addr_q == ROOT_ADDR) ? WORD_BITS'(1) : '0);
  assign tail = QIDX_W'(head_q + QIDX_W'(cnt_q));

  // Size to order: whole units, then ceiling power of two
  always_comb begin
    units = (div_res >> UNIT_SHIFT) + BOFF_W'(|div_res[UNIT_SHIFT-1:0]);
    kc    = ORD_W'(MAX_ORDER);
    for (int i = MAX_ORDER; i >= 0; i--) begin
      if ((BOFF_W'(1) << i) >= units) kc = ORD_W'(i);
    end
  end

  // Lowest free flag in the word just read
  always_comb begin
    lsb     = '0;
    lsb_hit = 1'b0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (rdw[i]) begin
        lsb     = BIT_W'(i);
        lsb_hit = 1'b1;
      end
    end
  end

  assign tgt  = off_q + UNIT_W'(1 << ord_q);
  assign bud  = off_q ^ UNIT_W'(1 << ord_q);
  assign tsum = (TOTAL_W+1)'(total_q) + (TOTAL_W+1)'(1 << k_q);
  assign relu = TOTAL_W'(1) << qord_q[head_q];

  // Sequence one command
  always_comb begin
    st_d       = st_q;
    cmd_d      = cmd_q;
    ord_d      = ord_q;
    k_d        = k_q;
    wrd_d      = wrd_q;
    off_d      = off_q;
    total_d    = total_q;
    freed_d    = freed_q;
    head_d     = head_q;
    cnt_d      = cnt_q;
    res_v_d    = res_v_q && !res_pop_i;
    res_st_d   = res_st_q;
    res_off_d  = res_off_q;
    res_ord_d  = res_ord_q;
    res_boff_d = res_boff_q;
    res_fr_d   = res_fr_q;
    cmd_pop_o  = 1'b0;
    q_wr       = 1'b0;
    rd_en      = 1'b0;
    rd_addr    = {ord_q, wrd_q};
    wr_en      = 1'b0;
    wr_addr    = rd_addr_q;
    wr_data    = rdw;
    div_start  = 1'b0;
    div_val    = cmd_q.size;
    div_aln    = cmd_q.align;

    case (st_q)
      BK_IDLE: begin
        if (cmd_valid_i && !res_v_q) begin
          cmd_pop_o  = 1'b1;
          cmd_d      = cmd_i;
          res_off_d  = '0;
          res_ord_d  = '0;
          res_boff_d = '0;
          res_fr_d   = '0;
          freed_d    = '0;
          case (cmd_i.op)
            OP_ALLOC: begin
              div_start = 1'b1;
              div_val   = cmd_i.size;
              div_aln   = cmd_i.align;
              st_d      = BK_A_DIV1;
            end
            OP_RELEASE: begin
              res_v_d = 1'b1;
              if (cnt_q >= QCNT_W'(QDEPTH)) begin
                res_st_d = ST_QFULL;
              end else begin
                res_st_d = ST_OK;
                q_wr     = 1'b1;
                cnt_d    = cnt_q + QCNT_W'(1);
              end
            end
            OP_CLEAN: st_d = BK_C_CHK;
            default: begin
              res_v_d  = 1'b1;
              res_st_d = ST_INVALID;
            end
          endcase
        end
      end

      BK_A_DIV1: begin
        if (div_done) begin
          if (div_res > BOFF_W'(POOL_BYTES) || total_q == TOTAL_W'(POOL_UNITS)) begin
            res_v_d  = 1'b1;
            res_st_d = ST_NOSPACE;
            st_d     = BK_IDLE;
          end else begin
            k_d   = kc;
            ord_d = kc;
            wrd_d = '0;
            st_d  = BK_A_RD;
          end
        end
      end

      BK_A_RD: begin
        rd_en = 1'b1;
        st_d  = BK_A_SCAN;
      end

      // Take the lowest free block of this order, else move on
      BK_A_SCAN: begin
        if (lsb_hit) begin
          wr_en   = 1'b1;
          wr_data = rdw & ~(WORD_BITS'(1) << lsb);
          off_d   = {wrd_q, lsb};
          total_d = (tsum > (TOTAL_W+1)'(POOL_UNITS)) ? TOTAL_W'(POOL_UNITS)
                                                    : TOTAL_W'(tsum);
          if (ord_q > k_q) begin
            ord_d = ord_q - ORD_W'(1);
            st_d  = BK_A_SPLIT_RD;
          end else begin
            st_d = BK_A_ADDR;
          end
        end else if (wrd_q == WIDX_W'(POOL_UNITS / WORD_BITS - 1)) begin
          if (ord_q == ORD_W'(MAX_ORDER)) begin
            res_v_d  = 1'b1;
            res_st_d = ST_NOSPACE;
            st_d     = BK_IDLE;
          end else begin
            ord_d = ord_q + ORD_W'(1);
            wrd_d = '0;
            st_d  = BK_A_RD;
          end
        end else begin
          wrd_d = wrd_q + WIDX_W'(1);
          st_d  = BK_A_RD;
        end
      end

      // Free the upper half at each split
      BK_A_SPLIT_RD: begin
        rd_en   = 1'b1;
        rd_addr = {ord_q, tgt[UNIT_W-1:BIT_W]};
        st_d    = BK_A_SPLIT_WR;
      end

      BK_A_SPLIT_WR: begin
        wr_en   = 1'b1;
        wr_data = rdw | (WORD_BITS'(1) << tgt[BIT_W-1:0]);
        if (ord_q == k_q) begin
          st_d = BK_A_ADDR;
        end else begin
          ord_d = ord_q - ORD_W'(1);
          st_d  = BK_A_SPLIT_RD;
        end
      end

      BK_A_ADDR: begin
        div_start = 1'b1;
        div_val   = SIZE_W'({off_q, UNIT_SHIFT'(0)});
        st_d      = BK_A_DIV2;
      end

      BK_A_DIV2: begin
        if (div_done) begin
          res_v_d    = 1'b1;
          res_st_d   = ST_OK;
          res_off_d  = off_q;
          res_ord_d  = k_q;
          res_boff_d = div_res;
          st_d       = BK_IDLE;
        end
      end

      // Drop expired releases from the queue head
      BK_C_CHK: begin
        if (cnt_q != '0 && qstamp_q[head_q] < cmd_q.frame) begin
          off_d   = qoff_q[head_q];
          ord_d   = qord_q[head_q];
          total_d = (total_q >= relu) ? total_q - relu : '0;
          head_d  = head_q + QIDX_W'(1);
          cnt_d   = cnt_q - QCNT_W'(1);
          freed_d = freed_q + QCNT_W'(1);
          st_d    = BK_F_RD;
        end else begin
          res_v_d  = 1'b1;
          res_st_d = ST_OK;
          res_fr_d = freed_q;
          st_d     = BK_IDLE;
        end
      end

      BK_F_RD: begin
        rd_en = 1'b1;
        if (ord_q == ORD_W'(MAX_ORDER)) begin
          rd_addr = {ord_q, off_q[UNIT_W-1:BIT_W]};
          st_d    = BK_F_SET_WR;
        end else begin
          rd_addr = {ord_q, bud[UNIT_W-1:BIT_W]};
          st_d    = BK_F_CHK;
        end
      end

      // Merge with a free buddy and climb one order
      BK_F_CHK: begin
        if (rdw[bud[BIT_W-1:0]]) begin
          wr_en   = 1'b1;
          wr_data = rdw & ~(WORD_BITS'(1) << bud[BIT_W-1:0]);
          off_d   = off_q & ~UNIT_W'(1 << ord_q);
          ord_d   = ord_q + ORD_W'(1);
          st_d    = BK_F_RD;
        end else begin
          st_d = BK_F_SET_RD;
        end
      end

      BK_F_SET_RD: begin
        rd_en   = 1'b1;
        rd_addr = {ord_q, off_q[UNIT_W-1:BIT_W]};
        st_d    = BK_F_SET_WR;
      end

      BK_F_SET_WR: begin
        wr_en   = 1'b1;
        wr_data = rdw | (WORD_BITS'(1) << off_q[BIT_W-1:0]);
        st_d    = BK_C_CHK;
      end

      default: st_d = BK_IDLE;
    endcase
  end

  // Flag memory ports
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      fmem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_q <= fmem[rd_addr];
      rd_addr_q <= rd_addr;
    end
  end

  // Row valid bits: an unwritten row reads as its reset pattern
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (wr_en) begin
      vld_q[wr_addr] <= 1'b1;
    end
  end

  // Release queue storage
  always_ff @(posedge clk_i) begin
    if (q_wr) begin
      qoff_q[tail]   <= cmd_i.offs;
      qord_q[tail]   <= cmd_i.order;
      qstamp_q[tail] <= cmd_i.frame;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    cmd_q      <= cmd_d;
    ord_q      <= ord_d;
    k_q        <= k_d;
    wrd_q      <= wrd_d;
    off_q      <= off_d;
    freed_q    <= freed_d;
    res_st_q   <= res_st_d;
    res_off_q  <= res_off_d;
    res_ord_q  <= res_ord_d;
    res_boff_q <= res_boff_d;
    res_fr_q   <= res_fr_d;
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= BK_IDLE;
      total_q <= '0;
      head_q  <= '0;
      cnt_q   <= '0;
      res_v_q <= 1'b0;
    end else begin
      st_q    <= st_d;
      total_q <= total_d;
      head_q  <= head_d;
      cnt_q   <= cnt_d;
      res_v_q <= res_v_d;
    end
  end

  assign res_valid_o           = res_v_q;
  assign status_o              = res_st_q;
  assign unit_offset_o         = res_off_q;
  assign alloc_order_o         = res_ord_q;
  assign aligned_byte_offset_o = res_boff_q;
  assign freed_count_o         = res_fr_q;

endmodule

### bench/buddy_block_allocator_core_tb.sv
// Self-checking testbench for the buddy block allocator core.
`timescale 1ns / 100ps

module buddy_block_allocator_core_tb;
  import bba_pkg::*;

  localparam logic [1:0] REQ_UNKNOWN = 2'd3;
  localparam int         NUM_RANDOM  = 1550;
  localparam int         TAIL_CYCLES = 400;

  typedef struct {
    logic [1:0]         status;
    logic [UNIT_W-1:0]  unit_off;
    logic [ORD_W-1:0]   order;
    logic [BOFF_W-1:0]  byte_off;
    logic [QCNT_W-1:0]  freed;
  } alloc_res_t;

  typedef struct {
    logic [1:0]         req;
    logic [SIZE_W-1:0]  size;
    logic [SIZE_W-1:0]  align;
    logic [UNIT_W-1:0]  offs;
    logic [ORD_W-1:0]   order;
    logic [FRAME_W-1:0] frame;
    int                 phase;
    bit                 hold;
    alloc_res_t         res;
  } request_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                push = 1'b0;
  logic                pop = 1'b0;
  logic [1:0]          req_type_i = '0;
  logic [SIZE_W-1:0]   size_bytes_i = '0;
  logic [SIZE_W-1:0]   alignment_i = '0;
  logic [UNIT_W-1:0]   block_offset_units_i = '0;
  logic [ORD_W-1:0]    block_order_i = '0;
  logic [FRAME_W-1:0]  frame_count_i = '0;
  logic                full, empty;
  logic [1:0]          status_o;
  logic [UNIT_W-1:0]   unit_offset_o;
  logic [ORD_W-1:0]    alloc_order_o;
  logic [BOFF_W-1:0]   aligned_byte_offset_o;
  logic [QCNT_W-1:0]   freed_count_o;

  buddy_block_allocator_core u_dut (
    .clk_i, .rst_ni, .push, .full, .req_type_i, .size_bytes_i, .alignment_i,
    .block_offset_units_i, .block_order_i, .frame_count_i, .empty, .pop,
    .status_o, .unit_offset_o, .alloc_order_o, .aligned_byte_offset_o,
    .freed_count_o
  );

  always #5 clk_i = ~clk_i;

  // Shadow allocator state
  bit                 free_map [0:MAX_ORDER][0:POOL_UNITS-1];
  int                 used_units;
  logic [UNIT_W-1:0]  rq_offs  [0:QDEPTH-1];
  logic [ORD_W-1:0]   rq_order [0:QDEPTH-1];
  logic [FRAME_W-1:0] rq_stamp [0:QDEPTH-1];
  int                 rq_head, rq_count;

  request_t   pending_q[$];
  alloc_res_t expected_q[$];
  int         n_total, n_sent, n_recv, errors;
  int         cur_phase;
  int         status_seen [0:3];
  bit         gen_done;

  function automatic longint unsigned round_to(longint unsigned v, longint unsigned a);
    if (a == 0) return v;
    return ((v + a - 1) / a) * a;
  endfunction

  // Free a block and merge free buddies upward
  function automatic void merge_free(int off, int ord);
    int units, buddy;
    units = 1 << ord;
    while (ord < MAX_ORDER) begin
      buddy = off ^ (1 << ord);
      if (!free_map[ord][buddy]) break;
      free_map[ord][buddy] = 0;
      if (buddy < off) off = buddy;
      ord++;
    end
    free_map[ord][off] = 1;
    used_units = (used_units >= units) ? used_units - units : 0;
  endfunction

  function automatic alloc_res_t predict_response(request_t it);
    alloc_res_t r;
    longint unsigned sz, units;
    int k, j, o, tail;
    r = '{default: '0};
    case (it.req)
      REQ_ALLOC: begin
        if (it.size == 0) begin
          r.status = ST_INVALID;
        end else begin
          sz = round_to(it.size, it.align);
          units = (sz + 255) / 256;
          k = 0;
          while (k <= MAX_ORDER && (64'd1 << k) < units) k++;
          r.status = ST_NOSPACE;
          if (sz <= POOL_BYTES && k <= MAX_ORDER && used_units != POOL_UNITS) begin
            for (j = k; j <= MAX_ORDER; j++) begin
              for (o = 0; o < POOL_UNITS; o += (1 << j))
                if (free_map[j][o]) break;
              if (o < POOL_UNITS) begin
                free_map[j][o] = 0;
                while (j > k) begin
                  j--;
                  free_map[j][o + (1 << j)] = 1;
                end
                used_units += 1 << k;
                if (used_units > POOL_UNITS) used_units = POOL_UNITS;
                r.status   = ST_OK;
                r.unit_off = UNIT_W'(o);
                r.order    = ORD_W'(k);
                r.byte_off = BOFF_W'(round_to(longint'(o) * 256, it.align));
                break;
              end
            end
          end
        end
      end
      REQ_RELEASE: begin
        if (it.order > MAX_ORDER || (int'(it.offs) & ((1 << it.order) - 1)) != 0) begin
          r.status = ST_INVALID;
        end else if (rq_count >= QDEPTH) begin
          r.status = ST_QFULL;
        end else begin
          tail = (rq_head + rq_count) % QDEPTH;
          rq_offs[tail]  = it.offs;
          rq_order[tail] = it.order;
          rq_stamp[tail] = it.frame;
          rq_count++;
        end
      end
      REQ_CLEAN: begin
        while (rq_count > 0 && rq_stamp[rq_head] < it.frame) begin
          merge_free(int'(rq_offs[rq_head]), int'(rq_order[rq_head]));
          rq_head = (rq_head + 1) % QDEPTH;
          rq_count--;
          r.freed++;
        end
      end
      default: r.status = ST_INVALID;
    endcase
    return r;
  endfunction

  function automatic alloc_res_t queue_request(logic [1:0] req, int size, int align,
                                               int offs, int ord, logic [31:0] frame,
                                               int phase, bit hold);
    request_t it;
    it.req = req; it.size = SIZE_W'(size); it.align = SIZE_W'(align);
    it.offs = UNIT_W'(offs); it.order = ORD_W'(ord); it.frame = frame;
    it.phase = phase; it.hold = hold;
    it.res = predict_response(it);
    pending_q.insert(pending_q.size(), it);
    return it.res;
  endfunction

  function automatic int send_idle_pct(int ph);
    return (ph == 0) ? 17 : (ph == 1) ? 73 : 0;
  endfunction

  function automatic int recv_idle_pct(int ph);
    return (ph == 0) ? 73 : (ph == 1) ? 17 : 0;
  endfunction

  // Build the request stream and release reset
  initial begin
    alloc_res_t r;
    int live_off[$], live_ord[$];
    int i, p, idx, ph, sz, al;
    logic [31:0] fr;
    foreach (free_map[a, b]) free_map[a][b] = 0;
    free_map[MAX_ORDER][0] = 1;
    used_units = 0; rq_head = 0; rq_count = 0;
    fr = $urandom_range(1000, 32'hF000_0000);

    // Directed corners
    void'(queue_request(REQ_ALLOC, 0, 0, 0, 0, 0, 0, 0));
    void'(queue_request(REQ_ALLOC, 65536, 0, 0, 0, 0, 0, 0));
    void'(queue_request(REQ_ALLOC, 1, 0, 0, 0, 0, 0, 0));
    void'(queue_request(REQ_RELEASE, 0, 0, 0, MAX_ORDER, fr, 0, 0));
    void'(queue_request(REQ_CLEAN, 0, 0, 0, 0, fr + 1, 0, 0));
    void'(queue_request(REQ_ALLOC, 1, 0, 0, 0, 0, 0, 0));
    void'(queue_request(REQ_ALLOC, 131071, 0, 0, 0, 0, 0, 0));
    void'(queue_request(REQ_ALLOC, 300, 65536, 0, 0, 0, 0, 0));
    void'(queue_request(REQ_ALLOC, 256, 1000, 0, 0, 0, 0, 0));
    void'(queue_request(REQ_ALLOC, 131071, 131071, 0, 0, 0, 0, 0));
    void'(queue_request(REQ_RELEASE, 0, 0, 0, 9, fr, 0, 0));
    void'(queue_request(REQ_RELEASE, 0, 0, 255, 15, fr, 0, 0));
    void'(queue_request(REQ_RELEASE, 0, 0, 1, 1, fr, 0, 0));
    void'(queue_request(REQ_UNKNOWN, 131071, 131071, 255, 15, 32'hFFFF_FFFF, 0, 0));
    // Overfill the release queue with double releases
    for (i = 0; i < QDEPTH + 1; i++)
      void'(queue_request(REQ_RELEASE, 0, 0, 0, 0, fr, 0, 0));
    void'(queue_request(REQ_CLEAN, 0, 0, 0, 0, 32'h0, 0, 0));
    void'(queue_request(REQ_CLEAN, 0, 0, 0, 0, 32'hFFFF_FFFF, 0, 0));

    // Random traffic: mostly alloc/release/cleanup cycles, some noise
    for (i = 0; i < NUM_RANDOM; i++) begin
      ph = (i < NUM_RANDOM / 3) ? 0 : (i < 2 * NUM_RANDOM / 3) ? 1 : 2;
      p = $urandom_range(0, 99);
      if (p < 45) begin
        if ($urandom_range(0, 9) == 0) begin
          sz = $urandom & 17'h1FFFF;
          al = $urandom & 17'h1FFFF;
        end else begin
          sz = $urandom_range(1, 2048);
          al = ($urandom_range(0, 2) == 0) ? 0 : (1 << $urandom_range(0, 12));
        end
        r = queue_request(REQ_ALLOC, sz, al, $urandom, $urandom, $urandom, ph,
                          i == NUM_RANDOM / 3 || i == 2 * NUM_RANDOM / 3);
        if (r.status == ST_OK) begin
          live_off.insert(live_off.size(), int'(r.unit_off));
          live_ord.insert(live_ord.size(), int'(r.order));
        end
      end else if (p < 75 && live_off.size() > 0) begin
        idx = $urandom_range(0, live_off.size() - 1);
        void'(queue_request(REQ_RELEASE, $urandom, $urandom, live_off[idx],
                            live_ord[idx], fr, ph, 0));
        // Leave a few blocks live to cause double releases
        if ($urandom_range(0, 19) != 0) begin
          live_off.delete(idx);
          live_ord.delete(idx);
        end
      end else if (p < 88) begin
        fr = fr + $urandom_range(1, 3);
        void'(queue_request(REQ_CLEAN, $urandom, $urandom, $urandom, $urandom, fr, ph, 0));
      end else begin
        void'(queue_request(2'($urandom_range(0, 3)), $urandom & 17'h1FFFF, $urandom,
                            $urandom, $urandom, $urandom, ph, 0));
      end
    end
    n_total = pending_q.size();

    // Reset the shadow state for the run itself
    foreach (free_map[a, b]) free_map[a][b] = 0;
    free_map[MAX_ORDER][0] = 1;
    used_units = 0; rq_head = 0; rq_count = 0;
    gen_done = 1;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // Driver: present the next pending request, hold it while full
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      push <= 1'b0;
    end else begin
      if (push && !full) begin
        expected_q.insert(expected_q.size(), pending_q[0].res);
        cur_phase = pending_q[0].phase;
        pending_q.delete(0);
        n_sent++;
      end
      if (!(push && full)) begin
        if (gen_done && pending_q.size() > 0 &&
            !(pending_q[0].hold && expected_q.size() != 0) &&
            $urandom_range(0, 99) >= send_idle_pct(pending_q[0].phase)) begin
          push                 <= 1'b1;
          req_type_i           <= pending_q[0].req;
          size_bytes_i         <= pending_q[0].size;
          alignment_i          <= pending_q[0].align;
          block_offset_units_i <= pending_q[0].offs;
          block_order_i        <= pending_q[0].order;
          frame_count_i        <= pending_q[0].frame;
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(string name, int exp_v, int act_v);
    if (exp_v != act_v) begin
      $error("%s mismatch: expected %0d, actual %0d", name, exp_v, act_v);
      errors++;
    end
  endtask

  // Monitor: compare each result transfer with the oldest expectation
  alloc_res_t mon_exp;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        n_recv++;
        if (expected_q.size() == 0) begin
          $error("result transfer with no request outstanding");
          errors++;
        end else begin
          mon_exp = expected_q[0];
          expected_q.delete(0);
          status_seen[mon_exp.status]++;
          check_field("status", int'(mon_exp.status), int'(status_o));
          check_field("unit_offset", int'(mon_exp.unit_off), int'(unit_offset_o));
          check_field("alloc_order", int'(mon_exp.order), int'(alloc_order_o));
          check_field("aligned_byte_offset", int'(mon_exp.byte_off),
                      int'(aligned_byte_offset_o));
          check_field("freed_count", int'(mon_exp.freed), int'(freed_count_o));
        end
      end
      pop <= ($urandom_range(0, 99) >= recv_idle_pct(cur_phase));
    end
  end

  // End of run
  initial begin
    wait (gen_done);
    wait (n_sent == n_total);
    wait (expected_q.size() == 0);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (expected_q.size() != 0) errors++;
    $display("Ran %0d requests, %0d results: ok %0d, no space %0d, queue full %0d, invalid %0d",
             n_total, n_recv, status_seen[0], status_seen[1], status_seen[2], status_seen[3]);
    $display("Covered alloc splits and rounding, deferred release, cleanup merges, rejects");
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #50_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
